// ===== rtl/irpd_pkg.sv =====
// shared types and constants for the pulse-distance command matcher
package irpd_pkg;

    localparam int CODE_W   = 7;
    localparam int TICK_W   = 16;
    localparam int BITS_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CODE_W-1:0] RST_TARGET_CODE = 7'h5E;
    localparam logic [TICK_W-1:0] RST_START_LOW   = 16'd740;
    localparam logic [TICK_W-1:0] RST_START_HIGH  = 16'd760;
    localparam logic [TICK_W-1:0] RST_ONE_LOW     = 16'd440;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH    = 16'd460;
    localparam logic [TICK_W-1:0] RST_HOLD_TICKS  = 16'd39063;
    localparam logic [BITS_W-1:0] BITS_PER_CODE   = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_CODE = 3'd0,
        CFG_START_LOW   = 3'd1,
        CFG_START_HIGH  = 3'd2,
        CFG_ONE_LOW     = 3'd3,
        CFG_ONE_HIGH    = 3'd4,
        CFG_HOLD_TICKS  = 3'd5
    } t_cfg_index;

    typedef enum logic {
        OP_INTERVAL = 1'b0,
        OP_TICK     = 1'b1
    } t_op;

    typedef struct packed {
        logic [CODE_W-1:0] target_code;
        logic [TICK_W-1:0] start_low;
        logic [TICK_W-1:0] start_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic              operation;
        logic [TICK_W-1:0] interval_ticks;
    } t_item;

    typedef struct packed {
        logic              output_on;
        logic              frame_done;
        logic [CODE_W-1:0] received_code;
        logic              code_matched;
    } t_result;

endpackage

// ===== rtl/irpd_cfg_regs.sv =====
// configuration register file with write-only port
module irpd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [irpd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output irpd_pkg::t_cfg                      o_cfg
);
    import irpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_code <= RST_TARGET_CODE;
            r_cfg.start_low   <= RST_START_LOW;
            r_cfg.start_high  <= RST_START_HIGH;
            r_cfg.one_low     <= RST_ONE_LOW;
            r_cfg.one_high    <= RST_ONE_HIGH;
            r_cfg.hold_ticks  <= RST_HOLD_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_CODE: r_cfg.target_code <= i_cfg_data[CODE_W-1:0];
                CFG_START_LOW:   r_cfg.start_low   <= i_cfg_data[TICK_W-1:0];
                CFG_START_HIGH:  r_cfg.start_high  <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_LOW:     r_cfg.one_low     <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_HIGH:    r_cfg.one_high    <= i_cfg_data[TICK_W-1:0];
                CFG_HOLD_TICKS:  r_cfg.hold_ticks  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/irpd_step.sv =====
// receiver and hold state with the single-pass update logic
module irpd_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  irpd_pkg::t_item   i_item,
    input  irpd_pkg::t_cfg    i_cfg,
    output irpd_pkg::t_result o_result
);
    import irpd_pkg::*;

    logic              r_start_seen;
    logic [BITS_W-1:0] r_bits_left;
    logic [CODE_W-1:0] r_code_shift;
    logic              r_hold_active;
    logic [TICK_W-1:0] r_hold_count;

    logic              n_start_seen;
    logic [BITS_W-1:0] n_bits_left;
    logic [CODE_W-1:0] n_code_shift;
    logic              n_hold_active;
    logic [TICK_W-1:0] n_hold_count;

    logic              start_hit;
    logic              one_hit;
    logic [BITS_W-1:0] pos;
    logic [TICK_W-1:0] count_inc;

    assign start_hit = (i_item.interval_ticks > i_cfg.start_low)
                    && (i_item.interval_ticks < i_cfg.start_high);
    assign one_hit   = (i_item.interval_ticks > i_cfg.one_low)
                    && (i_item.interval_ticks < i_cfg.one_high);
    assign pos       = r_bits_left - 3'd1;
    assign count_inc = r_hold_count + 16'd1;

    always_comb begin
        n_start_seen  = r_start_seen;
        n_bits_left   = r_bits_left;
        n_code_shift  = r_code_shift;
        n_hold_active = r_hold_active;
        n_hold_count  = r_hold_count;
        o_result      = '0;

        if (i_item.operation == OP_INTERVAL) begin
            if (!r_hold_active) begin
                if (!r_start_seen) begin
                    if (start_hit) begin
                        n_start_seen = 1'b1;
                    end
                end else begin
                    n_bits_left = pos;
                    if (one_hit && (pos != 3'd7)) begin
                        n_code_shift = r_code_shift | (7'd1 << pos);
                    end
                    if (pos == '0) begin
                        o_result.frame_done    = 1'b1;
                        o_result.received_code = n_code_shift;
                        o_result.code_matched  = (n_code_shift == i_cfg.target_code);
                        if (n_code_shift == i_cfg.target_code) begin
                            n_hold_active = 1'b1;
                            n_hold_count  = '0;
                        end
                        n_start_seen = 1'b0;
                        n_bits_left  = BITS_PER_CODE;
                        n_code_shift = '0;
                    end
                end
            end
        end else begin
            if (r_hold_active) begin
                n_hold_count = count_inc;
                if (count_inc == i_cfg.hold_ticks) begin
                    n_hold_active = 1'b0;
                    n_hold_count  = '0;
                    n_start_seen  = 1'b0;
                    n_bits_left   = BITS_PER_CODE;
                    n_code_shift  = '0;
                end
            end
        end

        o_result.output_on = n_hold_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seen  <= 1'b0;
            r_bits_left   <= BITS_PER_CODE;
            r_code_shift  <= '0;
            r_hold_active <= 1'b0;
            r_hold_count  <= '0;
        end else if (i_step) begin
            r_start_seen  <= n_start_seen;
            r_bits_left   <= n_bits_left;
            r_code_shift  <= n_code_shift;
            r_hold_active <= n_hold_active;
            r_hold_count  <= n_hold_count;
        end
    end

endmodule

// ===== rtl/ir_pulse_distance_command_matcher_unit.sv =====
// Pulse-distance infrared command matcher. Each request is either a measured
// interval between falling edges or a timeout tick; every request yields exactly
// one result. A request is taken into an input register; when the output register
// is free, the receiver state is updated by one pass of compare logic and the
// result lands in the output register. A new request is taken every cycle as long
// as the result side keeps draining. The output register
// and input register together let one request wait while a result is stalled.
module ir_pulse_distance_command_matcher_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [irpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_operation,
    input  logic [irpd_pkg::TICK_W-1:0]      i_interval_ticks,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_output_on,
    output logic                             o_frame_done,
    output logic [irpd_pkg::CODE_W-1:0]      o_received_code,
    output logic                             o_code_matched
);
    import irpd_pkg::*;

    t_cfg    cfg;
    t_result result;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    in_free;
    logic    step;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_free  = !r_in_valid || out_free;
    assign step     = r_in_valid && out_free;

    irpd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    irpd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in.operation      <= i_operation;
            r_in.interval_ticks <= i_interval_ticks;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_in_stall      = !in_free;
    assign o_out_valid     = r_out_valid;
    assign o_output_on     = r_out.output_on;
    assign o_frame_done    = r_out.frame_done;
    assign o_received_code = r_out.received_code;
    assign o_code_matched  = r_out.code_matched;

endmodule

// ===== rtl/irpd_checker.sv =====
// port-level checks for the command matcher and their binding
module irpd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic                             o_output_on,
    input  logic                             o_frame_done,
    input  logic [irpd_pkg::CODE_W-1:0]      o_received_code,
    input  logic                             o_code_matched
);
    import irpd_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // code fields are zero unless a frame completed
    a_idle_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |-> (o_received_code == '0 && !o_code_matched))
        else $error("code fields set without a completed frame");

    // a match always turns the output on
    a_match_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_code_matched) |-> o_output_on)
        else $error("match without output on");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_received_code)
            && $stable(o_output_on) && $stable(o_frame_done)))
        else $error("stalled result changed");

endmodule

bind ir_pulse_distance_command_matcher_unit irpd_checker u_irpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_output_on     (o_output_on),
    .o_frame_done    (o_frame_done),
    .o_received_code (o_received_code),
    .o_code_matched  (o_code_matched)
);
